@@ rtl/note_on_off_pairing_core_assert.svh @@
// Assertion macros used by the note pairing core.
`ifndef NOTE_ON_OFF_PAIRING_CORE_ASSERT_SVH
`define NOTE_ON_OFF_PAIRING_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define NOPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define NOPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nopc_pkg.sv @@
`default_nettype none

package nopc_pkg;

  localparam int OPEN_NOTES_DEF = 16;

  localparam logic [2:0] ST_OPENED    = 3'd0;
  localparam logic [2:0] ST_FINISHED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_UNMATCHED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [31:0] event_pos;
    logic [6:0]  event_pitch;
    logic [15:0] event_volume;
    logic        restart;
  } nopc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] note_start;
    logic [31:0] note_length;
    logic [6:0]  note_pitch;
    logic [15:0] note_volume;
  } nopc_out_t;

  // Event travelling down the cell row, with what it has gathered so far.
  typedef struct packed {
    logic        is_on;
    logic [6:0]  pitch;
    logic [31:0] pos;
    logic        hit;
    logic        free_found;
    logic [31:0] start;
    logic [15:0] volume;
  } nopc_tok_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } nopc_ctl_t;

  typedef struct packed {
    logic        en;
    logic [6:0]  pitch;
    logic [31:0] start;
    logic [15:0] volume;
  } nopc_wr_t;

endpackage

`default_nettype wire

@@ rtl/nopc_cell.sv @@
`default_nettype none

module nopc_cell #(
  parameter int IDX_W = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [IDX_W-1:0]     idx,
  input  wire nopc_pkg::nopc_ctl_t  ctl,
  input  wire nopc_pkg::nopc_wr_t   wr,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire logic                 tok_valid_in,
  input  wire nopc_pkg::nopc_tok_t  tok_in,
  input  wire logic [IDX_W-1:0]     free_in,
  output nopc_pkg::nopc_tok_t       tok_out,
  output logic                      tok_valid_out,
  output logic [IDX_W-1:0]          free_out
);
  import nopc_pkg::*;

  logic        vld;
  logic [6:0]  pitch;
  logic [31:0] start;
  logic [15:0] volume;

  logic             match;
  nopc_tok_t        tok_next;
  logic [IDX_W-1:0] free_next;

  assign match = vld && (pitch == tok_in.pitch);

  always_comb begin
    tok_next  = tok_in;
    free_next = free_in;
    if (match) begin
      tok_next.hit    = 1'b1;
      tok_next.start  = start;
      tok_next.volume = volume;
    end
    // The first empty cell the event passes is the lowest free entry.
    if (!vld && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      free_next           = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
      vld           <= 1'b0;
    end else begin
      if (ctl.advance) begin
        tok_valid_out <= tok_valid_in;
      end
      if (ctl.clear) begin
        vld <= 1'b0;
      end else if (ctl.advance && tok_valid_in && match && !tok_in.is_on) begin
        vld <= 1'b0;
      end else if (wr.en && (wr_idx == idx)) begin
        vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      tok_out  <= tok_next;
      free_out <= free_next;
    end
    if (wr.en && (wr_idx == idx)) begin
      pitch  <= wr.pitch;
      start  <= wr.start;
      volume <= wr.volume;
    end
  end

endmodule

`default_nettype wire

@@ rtl/note_on_off_pairing_core.sv @@
// Each accepted event is registered in a launch stage, then walks the row of OPEN_NOTES
// table cells, one cell per cycle while the row advances, and its result is registered.
// A new event is accepted only once the previous event's result has been registered.
// A result that is not taken holds the event at the end of the row.
// Reset (rst, synchronous) empties the open-note table and both channels.
`default_nettype none

`include "note_on_off_pairing_core_assert.svh"

module note_on_off_pairing_core #(
  parameter int OPEN_NOTES = nopc_pkg::OPEN_NOTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                evt_valid,
  output logic                     evt_ready,
  input  wire nopc_pkg::nopc_in_t  evt,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output nopc_pkg::nopc_out_t      res
);
  import nopc_pkg::*;

  localparam int IDX_W = (OPEN_NOTES > 1) ? $clog2(OPEN_NOTES) : 1;

  logic             busy;
  logic             accept;
  logic             consume;
  logic             lvalid;
  nopc_tok_t        ltok;
  nopc_ctl_t        ctl;
  nopc_wr_t         wr;
  logic [IDX_W-1:0] wr_idx;
  nopc_out_t        res_next;

  nopc_tok_t        tok_c  [0:OPEN_NOTES];
  logic             vld_c  [0:OPEN_NOTES];
  logic [IDX_W-1:0] free_c [0:OPEN_NOTES];

  nopc_tok_t        last_tok;
  logic             last_valid;
  logic [IDX_W-1:0] last_free;

  assign evt_ready = !busy;
  assign accept    = evt_valid && evt_ready;

  assign last_tok   = tok_c[OPEN_NOTES];
  assign last_valid = vld_c[OPEN_NOTES];
  assign last_free  = free_c[OPEN_NOTES];

  assign consume     = last_valid && (!res_valid || res_ready);
  assign ctl.advance = !last_valid || consume;
  assign ctl.clear   = accept && evt.restart;

  assign tok_c[0]  = ltok;
  assign vld_c[0]  = lvalid;
  assign free_c[0] = '0;

  for (genvar g = 0; g < OPEN_NOTES; g++) begin : g_cell
    nopc_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .idx          (IDX_W'(g)),
      .ctl          (ctl),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .tok_valid_in (vld_c[g]),
      .tok_in       (tok_c[g]),
      .free_in      (free_c[g]),
      .tok_out      (tok_c[g+1]),
      .tok_valid_out(vld_c[g+1]),
      .free_out     (free_c[g+1])
    );
  end

  // Resolve the event once it has seen every cell.
  always_comb begin
    wr.en     = 1'b0;
    wr.pitch  = last_tok.pitch;
    wr.start  = last_tok.pos;
    wr.volume = last_tok.volume;
    wr_idx    = last_free;
    res_next  = '0;
    if (last_tok.is_on) begin
      if (last_tok.hit) begin
        res_next.status = ST_DUPLICATE;
      end else if (!last_tok.free_found) begin
        res_next.status = ST_FULL;
      end else begin
        res_next.status = ST_OPENED;
        wr.en           = consume;
      end
    end else if (last_tok.hit) begin
      res_next.status      = ST_FINISHED;
      res_next.note_start  = last_tok.start;
      res_next.note_length = last_tok.pos - last_tok.start;
      res_next.note_pitch  = last_tok.pitch;
      res_next.note_volume = last_tok.volume;
    end else begin
      res_next.status = ST_UNMATCHED;
    end
  end

  // The launch stage carries the note-on volume in the volume field.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      lvalid    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy   <= 1'b1;
        lvalid <= 1'b1;
      end else begin
        if (consume) begin
          busy <= 1'b0;
        end
        if (ctl.advance) begin
          lvalid <= 1'b0;
        end
      end
      if (consume) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ltok.is_on      <= (evt.event_volume != 16'd0);
      ltok.pitch      <= evt.event_pitch;
      ltok.pos        <= evt.event_pos;
      ltok.hit        <= 1'b0;
      ltok.free_found <= 1'b0;
      ltok.start      <= '0;
      ltok.volume     <= evt.event_volume;
    end
    if (consume) begin
      res <= res_next;
    end
  end

  `NOPC_ASSERT_NOW(a_idle_row_empty, !busy, !last_valid && !lvalid, "event in row while idle")
  `NOPC_ASSERT_NOW(a_write_on_consume, wr.en, consume && last_tok.is_on, "stray table write")
  `NOPC_ASSERT_NEXT(a_consume_frees, consume, !busy && res_valid, "consume left block busy")
  `NOPC_ASSERT_NEXT(a_accept_launch, accept, lvalid && busy, "accepted event not launched")

endmodule

`default_nettype wire

@@ dv/tb_note_on_off_pairing_core.sv @@
`default_nettype none

module tb_note_on_off_pairing_core;
  timeunit 1ns;
  timeprecision 1ps;

  import nopc_pkg::*;

  localparam int OPEN_NOTES = OPEN_NOTES_DEF;
  localparam int RANDOM_EVENTS = 600;
  localparam int PITCH_POOL = 24;

  class note_scoreboard;
    bit              slot_busy[OPEN_NOTES];
    bit [6:0]        slot_pitch[OPEN_NOTES];
    bit [31:0]       slot_start[OPEN_NOTES];
    bit [15:0]       slot_volume[OPEN_NOTES];
    nopc_out_t       expected_notes[$];
    int              errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_notes.size();
    endfunction

    // Works out the result of one accepted event and updates the open-note table.
    function void note_event(nopc_in_t e);
      nopc_out_t r;
      int        hit;
      int        free_slot;
      r = '0;
      hit = -1;
      free_slot = -1;
      if (e.restart) begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      end
      // Walk downward so that the lowest free index wins.
      for (int i = OPEN_NOTES - 1; i >= 0; i--) begin
        if (slot_busy[i] && slot_pitch[i] == e.event_pitch) hit = i;
        if (!slot_busy[i]) free_slot = i;
      end
      if (e.event_volume != 16'd0) begin
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_busy[free_slot]   = 1'b1;
          slot_pitch[free_slot]  = e.event_pitch;
          slot_start[free_slot]  = e.event_pos;
          slot_volume[free_slot] = e.event_volume;
          r.status = ST_OPENED;
        end
      end else if (hit < 0) begin
        r.status = ST_UNMATCHED;
      end else begin
        r.status      = ST_FINISHED;
        r.note_start  = slot_start[hit];
        r.note_length = e.event_pos - slot_start[hit];
        r.note_pitch  = slot_pitch[hit];
        r.note_volume = slot_volume[hit];
        slot_busy[hit] = 1'b0;
      end
      expected_notes.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(nopc_out_t got);
      nopc_out_t want;
      if (expected_notes.size() == 0) begin
        $error("result item with no event outstanding, status %0d", got.status);
        errors++;
        return;
      end
      want = expected_notes.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("note_start", want.note_start, got.note_start);
      compare_field("note_length", want.note_length, got.note_length);
      compare_field("note_pitch", 32'(want.note_pitch), 32'(got.note_pitch));
      compare_field("note_volume", 32'(want.note_volume), 32'(got.note_volume));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      evt_valid = 1'b0;
  logic      evt_ready;
  nopc_in_t  evt = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  nopc_out_t res;

  note_scoreboard sb = new();
  bit             sender_calm = 1'b0;
  bit [31:0]      pos_cursor = 32'd0;
  bit [6:0]       pitch_pool[PITCH_POOL];

  note_on_off_pairing_core #(
    .OPEN_NOTES(OPEN_NOTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt      (evt),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always #2 clk = ~clk;

  task automatic send_event(input logic [31:0] pos, input logic [6:0] pitch,
                            input logic [15:0] volume, input bit restart);
    nopc_in_t e;
    int       gap;
    e.event_pos    = pos;
    e.event_pitch  = pitch;
    e.event_volume = volume;
    e.restart      = restart;
    gap = sender_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    do @(posedge clk); while (!evt_ready);
    sb.note_event(e);
  endtask

  task automatic send_random_event();
    logic [6:0]  pitch;
    logic [15:0] volume;
    int          pick;
    if ($urandom_range(0, 99) < 90) pitch = pitch_pool[$urandom_range(0, PITCH_POOL - 1)];
    else pitch = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 45) begin
      volume = 16'd0;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) volume = 16'd1;
      else if (pick == 1) volume = 16'hFFFF;
      else volume = 16'($urandom_range(1, 65535));
    end
    if ($urandom_range(0, 19) == 0) pos_cursor = $urandom;
    else pos_cursor = pos_cursor + $urandom_range(0, 70000);
    send_event(pos_cursor, pitch, volume, $urandom_range(0, 59) == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Restart together with a note-off: the table is cleared first.
    send_event(32'd0, 7'd0, 16'd0, 1'b1);
    send_event(32'h8000_0000, 7'd0, 16'd1, 1'b0);
    send_event(32'd5, 7'd0, 16'hFFFF, 1'b0);
    // Off just below the note's start position, so the length wraps around.
    send_event(32'h7FFF_FFFF, 7'd0, 16'd0, 1'b0);
    send_event(32'd10, 7'd127, 16'd0, 1'b0);
    for (int k = 0; k < OPEN_NOTES; k++) begin
      send_event(k * 1000, 7'(100 + k), 16'(k * 4099 + 1), 1'b0);
    end
    send_event(32'hFFFF_FFFF, 7'd127, 16'hFFFF, 1'b0);
    // Freeing one entry in the middle lets the next new note take it.
    send_event(32'd20000, 7'd107, 16'd0, 1'b0);
    send_event(32'd20001, 7'd127, 16'hFFFF, 1'b0);
    send_event(32'd19999, 7'd127, 16'd0, 1'b0);
    send_event(32'd30000, 7'd5, 16'h8000, 1'b1);

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 100 == 0) begin
        foreach (pitch_pool[i]) pitch_pool[i] = 7'($urandom_range(0, 127));
      end
      if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_EVENTS / 2) begin
        evt_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_event();
    end
    evt_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (OPEN_NOTES + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    int taken;
    bit receiver_calm;
    taken = 0;
    receiver_calm = 1'b0;
    @(negedge rst);
    forever begin
      if (taken % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
      taken++;
    end
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/nopc_pkg.sv
rtl/nopc_cell.sv
rtl/note_on_off_pairing_core.sv
dv/tb_note_on_off_pairing_core.sv
